// ----- rtl/masonry_shortest_track_placer_defines.svh -----
// assertion macros for the masonry shortest track placer
`ifndef MASONRY_SHORTEST_TRACK_PLACER_DEFINES_SVH
`define MASONRY_SHORTEST_TRACK_PLACER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MSTP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define MSTP_ASSERT(lbl, prop, msg)
`define MSTP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- rtl/mstp_pkg.sv -----
// types, constants and codes shared by the masonry placer modules
package mstp_pkg;

  localparam int MAX_TRACKS    = 16;
  localparam int FRACTION_BITS = 8;
  localparam int COORD_W       = 16 + FRACTION_BITS;
  localparam int REL_W         = 17;
  localparam int REL_FRAC      = 16;
  localparam int PROD_W        = REL_W + COORD_W;
  localparam int TRACK_IDX_W   = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int TRACK_CNT_W   = $clog2(MAX_TRACKS + 1);
  localparam int COUNT_REG_W   = 5;
  localparam int DIR_W         = 3;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = COORD_W;
  localparam int MUL_SEL_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_DIR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 2'd3;

  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd4;

  localparam logic [MUL_SEL_W-1:0] MUL_MAIN  = 2'd0;
  localparam logic [MUL_SEL_W-1:0] MUL_CROSS = 2'd1;
  localparam logic [MUL_SEL_W-1:0] MUL_POS   = 2'd2;

  typedef struct packed {
    logic             new_pass;
    logic [REL_W-1:0] rel_width;
    logic [REL_W-1:0] rel_height;
  } in_req_t;

  typedef struct packed {
    logic               placed;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
  } out_req_t;

  typedef struct packed {
    logic                 load;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic                 cap_main;
    logic                 scan_step;
    logic                 cap_other;
    logic                 cap_cross;
    logic                 store;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/mstp_div.sv -----
// restoring divider, one quotient bit per cycle, for the track size
module mstp_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mstp_pkg::COORD_W-1:0]     dividend_i,
  input  logic [mstp_pkg::TRACK_CNT_W-1:0] divisor_i,
  output logic                           busy_o,
  output logic [mstp_pkg::COORD_W-1:0]     quotient_o
);
  import mstp_pkg::*;

  localparam int STEP_W = $clog2(COORD_W + 1);

  logic                   busy_q;
  logic [STEP_W-1:0]      cnt_q;
  logic [COORD_W-1:0]     quo_q;
  logic [TRACK_CNT_W-1:0] rem_q;
  logic [TRACK_CNT_W-1:0] dsr_q;
  logic [TRACK_CNT_W:0]   shifted;
  logic [TRACK_CNT_W:0]   diff;
  logic                   ge;
  logic [TRACK_CNT_W-1:0] rem_d;
  logic [COORD_W-1:0]     quo_d;

  always_comb begin
    shifted = {rem_q, quo_q[COORD_W-1]};
    ge      = shifted >= {1'b0, dsr_q};
    diff    = shifted - {1'b0, dsr_q};
    rem_d   = ge ? diff[TRACK_CNT_W-1:0] : shifted[TRACK_CNT_W-1:0];
    quo_d   = {quo_q[COORD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= STEP_W'(COORD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/mstp_datapath.sv -----
// configuration, track fills, shared multiplier, fill scan and result register
module mstp_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mstp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mstp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  mstp_pkg::in_req_t             in_req_i,
  input  mstp_pkg::cmd_t                cmd_i,
  output mstp_pkg::sts_t                sts_o,
  output mstp_pkg::out_req_t            out_req_o
);
  import mstp_pkg::*;

  localparam int SCALED_W = PROD_W - REL_FRAC;

  logic [COUNT_REG_W-1:0] track_count_q;
  logic [DIR_W-1:0]       flow_dir_q;
  logic [COORD_W-1:0]     area_w_q;
  logic [COORD_W-1:0]     area_h_q;

  logic [DIR_W-1:0]       dir_eff;
  logic                   vertical;
  logic [TRACK_CNT_W-1:0] tracks_eff;
  logic [COORD_W-1:0]     cross_ext;
  logic [COORD_W-1:0]     main_ext;

  in_req_t                item_q;
  logic [COORD_W-1:0]     fill_q [MAX_TRACKS];

  logic [REL_W-1:0]       op_a;
  logic [COORD_W-1:0]     op_b;
  logic [PROD_W-1:0]      prod_q;
  logic [SCALED_W-1:0]    scaled;
  logic [COORD_W-1:0]     sat_size;

  logic [COORD_W-1:0]     imain_q;
  logic [COORD_W-1:0]     other_q;
  logic [COORD_W-1:0]     cross_q;

  logic [TRACK_IDX_W-1:0] idx_q;
  logic                   found_q;
  logic [TRACK_IDX_W-1:0] best_idx_q;
  logic [COORD_W-1:0]     best_fill_q;
  logic [COORD_W-1:0]     fill_rd;
  logic [COORD_W:0]       fit_sum;
  logic                   fits;
  logic                   better;

  logic                   div_busy;
  logic [COORD_W-1:0]     tsize;

  logic [COORD_W-1:0]     far_pos;
  logic [COORD_W-1:0]     item_w;
  logic [COORD_W-1:0]     item_h;
  out_req_t               out_d;
  out_req_t               out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_count_q <= COUNT_REG_W'(1);
      flow_dir_q    <= DIR_DOWN;
      area_w_q      <= '0;
      area_h_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRACK_COUNT: track_count_q <= cfg_data_i[COUNT_REG_W-1:0];
        CFG_FLOW_DIR:    flow_dir_q    <= cfg_data_i[DIR_W-1:0];
        CFG_AREA_WIDTH:  area_w_q      <= cfg_data_i[COORD_W-1:0];
        CFG_AREA_HEIGHT: area_h_q      <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dir_eff  = (flow_dir_q > DIR_NONE) ? DIR_NONE : flow_dir_q;
    vertical = (dir_eff == DIR_DOWN) || (dir_eff == DIR_UP);
    if (track_count_q == '0) begin
      tracks_eff = TRACK_CNT_W'(1);
    end else if (int'(track_count_q) > MAX_TRACKS) begin
      tracks_eff = TRACK_CNT_W'(MAX_TRACKS);
    end else begin
      tracks_eff = TRACK_CNT_W'(track_count_q);
    end
    cross_ext = vertical ? area_w_q : area_h_q;
    main_ext  = vertical ? area_h_q : area_w_q;
  end

  mstp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.load),
    .dividend_i (cross_ext),
    .divisor_i  (tracks_eff),
    .busy_o     (div_busy),
    .quotient_o (tsize)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_req_i;
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_MAIN: begin
        op_a = vertical ? item_q.rel_height : item_q.rel_width;
        op_b = main_ext;
      end
      MUL_CROSS: begin
        op_a = vertical ? item_q.rel_width : item_q.rel_height;
        op_b = tsize;
      end
      MUL_POS: begin
        op_a = REL_W'(best_idx_q);
        op_b = tsize;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  always_comb begin
    scaled   = prod_q[PROD_W-1:REL_FRAC];
    sat_size = ((scaled >> COORD_W) != '0) ? '1 : scaled[COORD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_main) begin
      imain_q <= sat_size;
    end
    if (cmd_i.cap_other) begin
      other_q <= sat_size;
    end
    if (cmd_i.cap_cross) begin
      cross_q <= prod_q[COORD_W-1:0];
    end
  end

  // fill scan
  always_comb begin
    fill_rd = fill_q[idx_q];
    fit_sum = {1'b0, fill_rd} + {1'b0, imain_q};
    fits    = fit_sum <= {1'b0, main_ext};
    better  = !found_q || (fill_rd < best_fill_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
    end else if (cmd_i.cap_main) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.scan_step) begin
      idx_q <= idx_q + TRACK_IDX_W'(1);
      if (fits && better) begin
        found_q    <= 1'b1;
        best_idx_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && fits && better) begin
      best_fill_q <= fill_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TRACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.load && in_req_i.new_pass) begin
      for (int i = 0; i < MAX_TRACKS; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cmd_i.store && found_q) begin
      fill_q[best_idx_q] <= best_fill_q + imain_q;
    end
  end

  // result
  always_comb begin
    far_pos = main_ext - best_fill_q - imain_q;
    item_w  = vertical ? other_q : imain_q;
    item_h  = vertical ? imain_q : other_q;
    out_d   = '0;
    if (found_q) begin
      out_d.placed = 1'b1;
      case (dir_eff)
        DIR_DOWN: begin
          out_d.rect_x      = cross_q;
          out_d.rect_y      = best_fill_q;
          out_d.rect_width  = item_w;
          out_d.rect_height = item_h;
        end
        DIR_UP: begin
          out_d.rect_x      = cross_q;
          out_d.rect_y      = far_pos;
          out_d.rect_width  = item_w;
          out_d.rect_height = item_h;
        end
        DIR_RIGHT: begin
          out_d.rect_x      = best_fill_q;
          out_d.rect_y      = cross_q;
          out_d.rect_width  = item_w;
          out_d.rect_height = item_h;
        end
        DIR_LEFT: begin
          out_d.rect_x      = far_pos;
          out_d.rect_y      = cross_q;
          out_d.rect_width  = item_w;
          out_d.rect_height = item_h;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      out_q <= out_d;
    end
  end

  assign sts_o.scan_last = (TRACK_CNT_W'(idx_q) == (tracks_eff - TRACK_CNT_W'(1)));
  assign sts_o.div_done  = !div_busy;
  assign out_req_o       = out_q;

endmodule

// ----- rtl/mstp_ctrl.sv -----
// sequencer for one placement request and the handshake flags
module mstp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  mstp_pkg::sts_t sts_i,
  output mstp_pkg::cmd_t cmd_o
);
  import mstp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_MAIN = 3'd1;
  localparam logic [2:0] S_CAP_MAIN = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_WAIT_DIV = 3'd4;
  localparam logic [2:0] S_MUL_POS  = 3'd5;
  localparam logic [2:0] S_CAP_POS  = 3'd6;
  localparam logic [2:0] S_STORE    = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_MAIN;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL_MAIN;
        end
      end
      S_MUL_MAIN: begin
        cmd_o.mul_sel = MUL_MAIN;
        state_d       = S_CAP_MAIN;
      end
      S_CAP_MAIN: begin
        cmd_o.cap_main = 1'b1;
        state_d        = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_WAIT_DIV;
        end
      end
      S_WAIT_DIV: begin
        cmd_o.mul_sel = MUL_CROSS;
        if (sts_i.div_done) begin
          state_d = S_MUL_POS;
        end
      end
      S_MUL_POS: begin
        cmd_o.cap_other = 1'b1;
        cmd_o.mul_sel   = MUL_POS;
        state_d         = S_CAP_POS;
      end
      S_CAP_POS: begin
        cmd_o.cap_cross = 1'b1;
        state_d         = S_STORE;
      end
      S_STORE: begin
        if (slot_free) begin
          cmd_o.store = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.store ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/masonry_shortest_track_placer.sv -----
// top level of the masonry shortest track placer
//
//   port group   direction  handshake               content
//   cfg          in         cfg_we_i                cfg_idx_i, cfg_data_i
//   in           in         in_valid_i / in_stall_o  in_req_i (new_pass, rel sizes)
//   out          out        out_valid_o / out_stall_i out_req_o (placed, rectangle)
//
// the 24-step track size divider, started on acceptance, is the longest step of a
// request; the scan over up to 16 track fills runs under it
// asynchronous active-low reset clears configuration, track fills and control
// a new request is taken while an earlier result still waits in the output register
// a stalled output holds its result and the next result waits for the slot
`include "masonry_shortest_track_placer_defines.svh"
module masonry_shortest_track_placer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mstp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mstp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mstp_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mstp_pkg::out_req_t            out_req_o
);
  import mstp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mstp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mstp_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_req_o  (out_req_o)
  );

  `MSTP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "accepted request did not make the block busy")
  `MSTP_ASSERT(a_store_slot_free, cmd.store |-> !(out_valid_o && out_stall_i), "result stored over a stalled result")
  `MSTP_ASSERT_NEXT(a_div_started, cmd.load, !sts.div_done, "divider not busy after load")
  `MSTP_ASSERT(a_unplaced_zero, (out_valid_o && !out_req_o.placed) |-> ((out_req_o.rect_x == '0) && (out_req_o.rect_y == '0) && (out_req_o.rect_width == '0) && (out_req_o.rect_height == '0)), "unplaced result has a nonzero rectangle")

endmodule

// ----- verif/tb_masonry_shortest_track_placer.sv -----
// testbench for the masonry shortest track placer: directed table, random passes, rect predictor
module tb_masonry_shortest_track_placer;
  timeunit 1ns;
  timeprecision 1ps;

  import mstp_pkg::*;

  localparam int unsigned RUN_LIMIT    = 500_000;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 112;
  localparam int          MAX_REPORTS  = 10;
  localparam longint unsigned COORD_MAX = (64'd1 << COORD_W) - 1;
  localparam logic [DIR_W-1:0] DIR_RSVD_TOP = 3'd7;
  localparam out_req_t NO_FIT    = '0;
  localparam out_req_t AT_ORIGIN = out_req_t'({1'b1, 96'd0});

  typedef struct {
    bit                     is_layout;
    logic [COUNT_REG_W-1:0] tracks;
    logic [DIR_W-1:0]       dir;
    logic [COORD_W-1:0]     aw;
    logic [COORD_W-1:0]     ah;
    in_req_t                req;
    bit                     typed;
    out_req_t               want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_TRACK_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_req_t               in_req_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_req_t              out_req_o;

  logic [COUNT_REG_W-1:0] lay_tracks = COUNT_REG_W'(1);
  logic [DIR_W-1:0]       lay_dir = DIR_DOWN;
  logic [COORD_W-1:0]     lay_aw = '0;
  logic [COORD_W-1:0]     lay_ah = '0;
  logic [COORD_W-1:0]     fill_lvl [MAX_TRACKS];

  out_req_t    pending_rects [$];
  plan_row_t   plan [$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_arm = 1'b0;
  bit          offering = 1'b0;

  masonry_shortest_track_placer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned scaled_size(longint unsigned rel, longint unsigned ext);
    longint unsigned v;
    v = (rel * ext) >> REL_FRAC;
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  function automatic out_req_t place_item(in_req_t req);
    longint unsigned tracks, cross_ext, main_ext, tsize, iw, ih, imain, cpos, mpos;
    logic [DIR_W-1:0] dir;
    bit               vert;
    int               best;
    out_req_t         res;
    if (req.new_pass) begin
      foreach (fill_lvl[i]) fill_lvl[i] = '0;
    end
    tracks = lay_tracks;
    if (tracks == 0) tracks = 1;
    if (tracks > MAX_TRACKS) tracks = MAX_TRACKS;
    dir = (lay_dir > DIR_NONE) ? DIR_NONE : lay_dir;
    vert = (dir == DIR_DOWN) || (dir == DIR_UP);
    cross_ext = vert ? lay_aw : lay_ah;
    main_ext = vert ? lay_ah : lay_aw;
    tsize = cross_ext / tracks;
    iw = scaled_size(req.rel_width, vert ? tsize : longint'(lay_aw));
    ih = scaled_size(req.rel_height, vert ? longint'(lay_ah) : tsize);
    imain = vert ? ih : iw;
    best = -1;
    for (int i = 0; i < tracks; i++) begin
      if (fill_lvl[i] + imain <= main_ext && (best < 0 || fill_lvl[i] < fill_lvl[best])) begin
        best = i;
      end
    end
    res = '0;
    if (best >= 0) begin
      cpos = longint'(best) * tsize;
      mpos = fill_lvl[best];
      res.placed = 1'b1;
      case (dir)
        DIR_DOWN: begin
          res.rect_x = COORD_W'(cpos);
          res.rect_y = COORD_W'(mpos);
        end
        DIR_UP: begin
          res.rect_x = COORD_W'(cpos);
          res.rect_y = COORD_W'(main_ext - mpos - ih);
        end
        DIR_RIGHT: begin
          res.rect_x = COORD_W'(mpos);
          res.rect_y = COORD_W'(cpos);
        end
        DIR_LEFT: begin
          res.rect_x = COORD_W'(main_ext - mpos - iw);
          res.rect_y = COORD_W'(cpos);
        end
        default: ;
      endcase
      if (dir != DIR_NONE) begin
        res.rect_width = COORD_W'(iw);
        res.rect_height = COORD_W'(ih);
      end
      fill_lvl[best] = COORD_W'(mpos + imain);
    end
    return res;
  endfunction

  function automatic plan_row_t layout_row(logic [COUNT_REG_W-1:0] tracks, logic [DIR_W-1:0] dir,
                                           logic [COORD_W-1:0] aw, logic [COORD_W-1:0] ah);
    plan_row_t r;
    r = '{1'b1, tracks, dir, aw, ah, '0, 1'b0, NO_FIT};
    return r;
  endfunction

  function automatic plan_row_t req_row(bit np, logic [REL_W-1:0] w, logic [REL_W-1:0] h,
                                        bit typed, out_req_t want);
    plan_row_t r;
    r = '{1'b0, '0, DIR_DOWN, '0, '0, in_req_t'({np, w, h}), typed, want};
    return r;
  endfunction

  function automatic logic [REL_W-1:0] pick_rel();
    case ($urandom_range(9))
      0: return 17'h10000;
      1: return REL_W'($urandom_range(0, 17'h1FFFF));
      2, 3: return REL_W'($urandom_range(0, 17'h10000));
      default: return REL_W'($urandom_range(0, 17'h4000));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_extent();
    case ($urandom_range(7))
      0: return '1;
      1: return '0;
      2, 3: return COORD_W'($urandom_range(1, 24'h00FFFF));
      default: return COORD_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [COUNT_REG_W-1:0] pick_tracks();
    if ($urandom_range(3) == 0) return COUNT_REG_W'($urandom_range(0, (1 << COUNT_REG_W) - 1));
    return COUNT_REG_W'($urandom_range(1, MAX_TRACKS));
  endfunction

  function automatic in_req_t rand_req();
    in_req_t r;
    r.new_pass = ($urandom_range(11) == 0);
    r.rel_width = pick_rel();
    r.rel_height = pick_rel();
    return r;
  endfunction

  task automatic set_layout(logic [COUNT_REG_W-1:0] tracks, logic [DIR_W-1:0] dir,
                            logic [COORD_W-1:0] aw, logic [COORD_W-1:0] ah);
    logic [CFG_IDX_W-1:0]  regs [4];
    logic [CFG_DATA_W-1:0] vals [4];
    regs = '{CFG_TRACK_COUNT, CFG_FLOW_DIR, CFG_AREA_WIDTH, CFG_AREA_HEIGHT};
    vals = '{CFG_DATA_W'(tracks), CFG_DATA_W'(dir), aw, ah};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= regs[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    lay_tracks = tracks;
    lay_dir = dir;
    lay_aw = aw;
    lay_ah = ah;
  endtask

  task automatic offer(in_req_t req, bit typed, out_req_t want);
    out_req_t due;
    in_valid_i <= 1'b1;
    in_req_i <= req;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    due = place_item(req);
    pending_rects.push_back(typed ? want : due);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic drain();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
    while (pending_rects.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_arm) begin
        hold_arm = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_rects
    out_req_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rects.size() == 0) begin
        if (mismatches < MAX_REPORTS) $display("unexpected result: got %h", out_req_o);
        mismatches++;
      end else begin
        want = pending_rects.pop_front();
        if (out_req_o.placed !== want.placed || out_req_o.rect_x !== want.rect_x ||
            out_req_o.rect_y !== want.rect_y || out_req_o.rect_width !== want.rect_width ||
            out_req_o.rect_height !== want.rect_height) begin
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch: exp placed=%0d x=%h y=%h w=%h h=%h", want.placed,
                     want.rect_x, want.rect_y, want.rect_width, want.rect_height);
            $display("          got placed=%0d x=%h y=%h w=%h h=%h", out_req_o.placed,
                     out_req_o.rect_x, out_req_o.rect_y, out_req_o.rect_width,
                     out_req_o.rect_height);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    foreach (fill_lvl[i]) fill_lvl[i] = '0;

    // after reset the area is empty, so every item lands at the origin with zero size
    plan.push_back(req_row(1'b0, 17'h10000, 17'h10000, 1'b1, AT_ORIGIN));
    plan.push_back(req_row(1'b1, 17'h00000, 17'h1FFFF, 1'b1, AT_ORIGIN));
    plan.push_back(layout_row(COUNT_REG_W'(2), DIR_DOWN, 24'hFFFFFF, 24'h001000));
    plan.push_back(req_row(1'b1, 17'h1FFFF, 17'h1FFFF, 1'b1, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h10000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h10000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h0FFFF, 17'h00001, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h10000, 17'h10000, 1'b1, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(2), DIR_UP, 24'h000800, 24'h001000));
    plan.push_back(req_row(1'b1, 17'h08000, 17'h08000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h1FFFF, 17'h08000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h00001, 17'h08000, 1'b0, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(3), DIR_RIGHT, 24'h001000, 24'h000C00));
    plan.push_back(req_row(1'b1, 17'h08000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h04000, 17'h1FFFF, 1'b0, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(3), DIR_LEFT, 24'h001000, 24'h000C00));
    plan.push_back(req_row(1'b1, 17'h08000, 17'h08000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h10000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(4), DIR_NONE, 24'h001000, 24'h001000));
    plan.push_back(req_row(1'b1, 17'h08000, 17'h08000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h1FFFF, 17'h08000, 1'b1, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(4), DIR_RSVD_TOP, 24'h001000, 24'h001000));
    plan.push_back(req_row(1'b0, 17'h04000, 17'h04000, 1'b0, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(0), DIR_DOWN, 24'hFFFFFF, 24'hFFFFFF));
    plan.push_back(req_row(1'b1, 17'h10000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h00001, 17'h00001, 1'b0, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(31), DIR_RIGHT, 24'hFFFFFF, 24'hFFFFFF));
    plan.push_back(req_row(1'b1, 17'h01000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h01000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(layout_row(COUNT_REG_W'(8), DIR_RIGHT, 24'hFFFFFF, 24'hFFFFFF));
    plan.push_back(req_row(1'b0, 17'h01000, 17'h10000, 1'b0, NO_FIT));
    plan.push_back(req_row(1'b0, 17'h1FFFF, 17'h1FFFF, 1'b0, NO_FIT));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_layout) begin
        drain();
        set_layout(plan[i].tracks, plan[i].dir, plan[i].aw, plan[i].ah);
      end else begin
        offer(plan[i].req, plan[i].typed, plan[i].want);
      end
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      if (p == 0) set_layout(COUNT_REG_W'(MAX_TRACKS), DIR_DOWN, '1, '1);
      else set_layout(pick_tracks(), DIR_W'($urandom_range(0, DIR_RSVD_TOP)), pick_extent(),
                      pick_extent());
      // long output hold-off so the block backs up into its input
      if (p == 4) hold_arm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) offer(rand_req(), 1'b0, NO_FIT);
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
